// ===== rtl/quaternion_log_attitude_error_assert.svh =====
// Assertion macros for the quaternion log attitude error block.
// Used by the top level; expects clk and rst_n in scope.
`ifndef QUATERNION_LOG_ATTITUDE_ERROR_ASSERT_SVH
`define QUATERNION_LOG_ATTITUDE_ERROR_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define QLAE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset
`define QLAE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/qlae_pkg.sv =====
// Package for the quaternion log attitude error block: types, stage step
// functions for the root, divider and CORDIC pipelines, atan table. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package qlae_pkg;

    localparam int SQ_STEPS     = 32;
    localparam int DIV_STEPS    = 32;
    localparam int CORDIC_STEPS = 16;
    localparam logic [7:0] LIMIT_RESET = 8'd1;

    typedef logic signed [15:0] comp_t;
    typedef logic signed [32:0] nq_t;
    typedef logic [3:0][15:0]   quat16_t;
    typedef logic [3:0][32:0]   quat33_t;

    // integer square root state: remaining value and partial root
    typedef struct packed {
        logic [63:0] v;
        logic [63:0] r;
    } sq_t;

    // long division state: divisor, partial remainder, numerator/quotient bits
    typedef struct packed {
        logic [47:0] d;
        logic [47:0] pr;
        logic [31:0] lo;
        logic        neg;
    } dv_t;

    // CORDIC vectoring state
    typedef struct packed {
        logic signed [35:0] x;
        logic signed [35:0] y;
        logic signed [33:0] z;
    } cr_t;

    function automatic sq_t sq_init(logic [63:0] v);
        sq_t o;
        o.v = v;
        o.r = '0;
        return o;
    endfunction

    // one digit of the bitwise square root
    function automatic sq_t sq_step(sq_t s, int k);
        sq_t o;
        logic [63:0] b;
        logic [63:0] t;
        b = 64'd1 << (62 - 2 * k);
        t = s.r + b;
        if (s.v >= t)
        begin
            o.v = s.v - t;
            o.r = (s.r >> 1) + b;
        end
        else
        begin
            o.v = s.v;
            o.r = s.r >> 1;
        end
        return o;
    endfunction

    // add half the divisor for round half away from zero, split numerator
    function automatic dv_t dv_init(logic [63:0] mag, logic [47:0] d, logic neg);
        dv_t o;
        logic [63:0] n;
        n     = mag + {17'd0, d[47:1]};
        o.d   = d;
        o.pr  = {16'd0, n[63:32]};
        o.lo  = n[31:0];
        o.neg = neg;
        return o;
    endfunction

    // one quotient bit of restoring division
    function automatic dv_t dv_step(dv_t s);
        dv_t o;
        logic [48:0] t;
        logic q;
        t = {s.pr, s.lo[31]};
        q = (t >= {1'b0, s.d});
        o = s;
        o.pr = q ? 48'(t - {1'b0, s.d}) : t[47:0];
        o.lo = {s.lo[30:0], q};
        return o;
    endfunction

    function automatic nq_t dv_result(dv_t s);
        nq_t m;
        m = $signed({1'b0, s.lo});
        return s.neg ? -m : m;
    endfunction

    function automatic logic [32:0] mag33(nq_t v);
        return v[32] ? 33'(-v) : 33'(v);
    endfunction

    // atan(2^-k) in Q.30
    function automatic logic signed [33:0] atan_c(int k);
        logic signed [33:0] a;
        case (k)
            0:  a = 34'sd843314856;
            1:  a = 34'sd497837829;
            2:  a = 34'sd263043836;
            3:  a = 34'sd133525158;
            4:  a = 34'sd67021686;
            5:  a = 34'sd33543515;
            6:  a = 34'sd16775850;
            7:  a = 34'sd8388437;
            8:  a = 34'sd4194282;
            9:  a = 34'sd2097149;
            10: a = 34'sd1048575;
            11: a = 34'sd524287;
            12: a = 34'sd262143;
            13: a = 34'sd131071;
            14: a = 34'sd65535;
            15: a = 34'sd32767;
            16: a = 34'sd16383;
            17: a = 34'sd8191;
            18: a = 34'sd4095;
            19: a = 34'sd2047;
            20: a = 34'sd1023;
            21: a = 34'sd511;
            22: a = 34'sd255;
            23: a = 34'sd127;
            24: a = 34'sd63;
            25: a = 34'sd31;
            26: a = 34'sd15;
            27: a = 34'sd8;
            28: a = 34'sd4;
            29: a = 34'sd2;
            30: a = 34'sd1;
            default: a = 34'sd0;
        endcase
        return a;
    endfunction

    // one CORDIC vectoring rotation, driving y toward zero
    function automatic cr_t cr_step(cr_t s, int k);
        cr_t o;
        logic signed [35:0] xs;
        logic signed [35:0] ys;
        xs = $signed(s.x) >>> k;
        ys = $signed(s.y) >>> k;
        if (!s.y[35])
        begin
            o.x = s.x + ys;
            o.y = s.y - xs;
            o.z = s.z + atan_c(k);
        end
        else
        begin
            o.x = s.x - ys;
            o.y = s.y + xs;
            o.z = s.z - atan_c(k);
        end
        return o;
    endfunction

    // round half away from zero by 2^30
    function automatic nq_t rnd30(logic signed [63:0] s);
        logic [63:0] m;
        logic [63:0] q;
        nq_t r;
        m = s[63] ? 64'(-s) : 64'(s);
        q = (m + (64'd1 << 29)) >> 30;
        r = $signed(q[32:0]);
        return s[63] ? -r : r;
    endfunction

    function automatic logic signed [16:0] sat17(logic signed [32:0] v);
        if (v < -33'sd65536)
            return -17'sd65536;
        else if (v > 33'sd65535)
            return 17'sd65535;
        return v[16:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/quaternion_log_attitude_error.sv =====
// Quaternion log attitude error, fully pipelined; uses qlae_pkg and the assert header.
// Throughput: one item per cycle; busy stays low, done is never held off.
// Sequence: square sums, two roots, 8 dividers, quaternion product, root, 4 dividers,
// root, 16-step CORDIC, 3 dividers; each root and divider is 32 one-bit stages.
// Reset (rst_n, async low) clears all valid bits and sets the limit register to 1.
`timescale 1ns / 1ps
`default_nettype none
`include "quaternion_log_attitude_error_assert.svh"

module quaternion_log_attitude_error (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic                cfg_we,
    input  logic [7:0]          cfg_wdata,
    input  qlae_pkg::comp_t     measured_w,
    input  qlae_pkg::comp_t     measured_x,
    input  qlae_pkg::comp_t     measured_y,
    input  qlae_pkg::comp_t     measured_z,
    input  qlae_pkg::comp_t     predicted_w,
    input  qlae_pkg::comp_t     predicted_x,
    input  qlae_pkg::comp_t     predicted_y,
    input  qlae_pkg::comp_t     predicted_z,
    output logic                done,
    output logic signed [16:0]  rot_x,
    output logic signed [16:0]  rot_y,
    output logic signed [16:0]  rot_z,
    output logic                degenerate
);
    import qlae_pkg::*;

    typedef struct packed {
        quat16_t m;
        quat16_t p;
        logic    zero;
    } c1_t;

    typedef struct packed {
        quat33_t q;
        logic    zero;
    } c2_t;

    typedef struct packed {
        logic [2:0][32:0] nv;
        logic [31:0]      vn;
        logic             small_ang;
        logic             zero;
    } c4_t;

    typedef struct packed {
        logic [2:0][19:0] sr;
        logic             small_ang;
        logic             zero;
    } c5_t;

    // config register
    logic [7:0] limit_reg;

    // stage 1: input capture and square sums
    logic             s1_vld_reg;
    quat16_t          s1_m_reg, s1_p_reg;
    logic [32:0]      s1_s2m_reg, s1_s2p_reg;
    logic [32:0]      s2m_next, s2p_next;
    logic signed [31:0] msq [4];
    logic signed [31:0] psq [4];

    // first root
    logic [SQ_STEPS:0] sq1_vld_reg;
    sq_t  sq1m_reg [SQ_STEPS+1];
    sq_t  sq1p_reg [SQ_STEPS+1];
    c1_t  sq1_c_reg [SQ_STEPS+1];

    // input normalization dividers, lanes 0..3 measured, 4..7 predicted
    logic [DIV_STEPS:0] dv1_vld_reg;
    logic [DIV_STEPS:0] dv1_zero_reg;
    dv_t  dv1_reg [8][DIV_STEPS+1];

    // error product
    logic               p1_vld_reg, p2_vld_reg, p3_vld_reg, p4_vld_reg;
    logic               p5_vld_reg, p6_vld_reg;
    logic               p1_zero_reg, p2_zero_reg, p3_zero_reg, p4_zero_reg;
    logic               p5_zero_reg, p6_zero_reg;
    logic signed [31:0] pn32 [4];
    logic signed [31:0] mn32 [4];
    logic signed [63:0] p1_prod_reg [4][4];
    logic signed [63:0] p2_sum_reg [4];
    nq_t                p3_e_reg [4];
    quat33_t            p4_e_reg, p5_e_reg, p6_e_reg;
    logic [63:0]        p5_sq_reg [4];
    logic [63:0]        p6_s2_reg;

    // error norm root
    logic [SQ_STEPS:0] sq2_vld_reg;
    sq_t  sq2_reg [SQ_STEPS+1];
    c2_t  sq2_c_reg [SQ_STEPS+1];

    // error normalization dividers
    logic [DIV_STEPS:0] dv2_vld_reg;
    logic [DIV_STEPS:0] dv2_zero_reg;
    dv_t  dv2_reg [4][DIV_STEPS+1];
    logic [31:0] en;
    logic        zero2;

    // vector norm
    logic        n1_vld_reg, n2_vld_reg;
    logic        n1_zero_reg, n2_zero_reg;
    quat33_t     n1_n_reg, n2_n_reg;
    logic [63:0] n1_sq_reg [3];
    logic [63:0] n2_s2_reg;
    logic [SQ_STEPS:0] sq3_vld_reg;
    sq_t  sq3_reg [SQ_STEPS+1];
    c2_t  sq3_c_reg [SQ_STEPS+1];
    logic [31:0] vn;

    // CORDIC
    logic [CORDIC_STEPS:0] cr_vld_reg;
    cr_t  cr_reg [CORDIC_STEPS+1];
    c4_t  cr_c_reg [CORDIC_STEPS+1];

    // angle scaling
    logic               m1_vld_reg;
    logic signed [67:0] m1_prod_reg [3];
    c5_t                m1_c_reg;
    logic [31:0]        m1_vn_reg;
    logic signed [34:0] angle;

    // final dividers
    logic [DIV_STEPS:0] dv3_vld_reg;
    dv_t  dv3_reg [3][DIV_STEPS+1];
    c5_t  dv3_c_reg [DIV_STEPS+1];

    // output registers
    logic               done_reg;
    logic signed [16:0] rot_reg [3];
    logic               degenerate_reg;

    comp_t in_m [4];
    comp_t in_p [4];

    assign in_m[0] = measured_w;
    assign in_m[1] = measured_x;
    assign in_m[2] = measured_y;
    assign in_m[3] = measured_z;
    assign in_p[0] = predicted_w;
    assign in_p[1] = predicted_x;
    assign in_p[2] = predicted_y;
    assign in_p[3] = predicted_z;

    assign busy = 1'b0;

    // square sums of both inputs
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            msq[i] = in_m[i] * in_m[i];
            psq[i] = in_p[i] * in_p[i];
        end
        s2m_next = 33'(msq[0]) + 33'(msq[1]) + 33'(msq[2]) + 33'(msq[3]);
        s2p_next = 33'(psq[0]) + 33'(psq[1]) + 33'(psq[2]) + 33'(psq[3]);
    end

    // normalized inputs, error norm, vector norm, angle
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            mn32[i] = 32'(dv_result(dv1_reg[i][DIV_STEPS]));
            pn32[i] = 32'(dv_result(dv1_reg[i+4][DIV_STEPS]));
        end
        en    = sq2_reg[SQ_STEPS].r[31:0];
        zero2 = sq2_c_reg[SQ_STEPS].zero || (en == 32'd0);
        vn    = sq3_reg[SQ_STEPS].r[31:0];
        angle = {cr_reg[CORDIC_STEPS].z, 1'b0};
    end

    // control: valid bits and config
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg   <= LIMIT_RESET;
            s1_vld_reg  <= 1'b0;
            sq1_vld_reg <= '0;
            dv1_vld_reg <= '0;
            p1_vld_reg  <= 1'b0;
            p2_vld_reg  <= 1'b0;
            p3_vld_reg  <= 1'b0;
            p4_vld_reg  <= 1'b0;
            p5_vld_reg  <= 1'b0;
            p6_vld_reg  <= 1'b0;
            sq2_vld_reg <= '0;
            dv2_vld_reg <= '0;
            n1_vld_reg  <= 1'b0;
            n2_vld_reg  <= 1'b0;
            sq3_vld_reg <= '0;
            cr_vld_reg  <= '0;
            m1_vld_reg  <= 1'b0;
            dv3_vld_reg <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                limit_reg <= cfg_wdata;
            s1_vld_reg  <= start && !busy;
            sq1_vld_reg <= {sq1_vld_reg[SQ_STEPS-1:0], s1_vld_reg};
            dv1_vld_reg <= {dv1_vld_reg[DIV_STEPS-1:0], sq1_vld_reg[SQ_STEPS]};
            p1_vld_reg  <= dv1_vld_reg[DIV_STEPS];
            p2_vld_reg  <= p1_vld_reg;
            p3_vld_reg  <= p2_vld_reg;
            p4_vld_reg  <= p3_vld_reg;
            p5_vld_reg  <= p4_vld_reg;
            p6_vld_reg  <= p5_vld_reg;
            sq2_vld_reg <= {sq2_vld_reg[SQ_STEPS-1:0], p6_vld_reg};
            dv2_vld_reg <= {dv2_vld_reg[DIV_STEPS-1:0], sq2_vld_reg[SQ_STEPS]};
            n1_vld_reg  <= dv2_vld_reg[DIV_STEPS];
            n2_vld_reg  <= n1_vld_reg;
            sq3_vld_reg <= {sq3_vld_reg[SQ_STEPS-1:0], n2_vld_reg};
            cr_vld_reg  <= {cr_vld_reg[CORDIC_STEPS-1:0], sq3_vld_reg[SQ_STEPS]};
            m1_vld_reg  <= cr_vld_reg[CORDIC_STEPS];
            dv3_vld_reg <= {dv3_vld_reg[DIV_STEPS-1:0], m1_vld_reg};
            done_reg    <= dv3_vld_reg[DIV_STEPS];
        end
    end

    // front end: capture, first root, input normalization
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 4; i++)
        begin
            s1_m_reg[i] <= in_m[i];
            s1_p_reg[i] <= in_p[i];
        end
        s1_s2m_reg <= s2m_next;
        s1_s2p_reg <= s2p_next;

        sq1m_reg[0]         <= sq_init({31'd0, s1_s2m_reg} << 28);
        sq1p_reg[0]         <= sq_init({31'd0, s1_s2p_reg} << 28);
        sq1_c_reg[0].m      <= s1_m_reg;
        sq1_c_reg[0].p      <= s1_p_reg;
        sq1_c_reg[0].zero   <= (s1_s2m_reg == 33'd0) || (s1_s2p_reg == 33'd0);
        for (int k = 0; k < SQ_STEPS; k++)
        begin
            sq1m_reg[k+1]  <= sq_step(sq1m_reg[k], k);
            sq1p_reg[k+1]  <= sq_step(sq1p_reg[k], k);
            sq1_c_reg[k+1] <= sq1_c_reg[k];
        end

        // divide q * 2^44 by the root
        for (int i = 0; i < 4; i++)
        begin
            dv1_reg[i][0] <= dv_init(
                {4'd0, 16'(mag33(33'(signed'(sq1_c_reg[SQ_STEPS].m[i])))), 44'd0},
                sq1_c_reg[SQ_STEPS].zero ? 48'd1 : {16'd0, sq1m_reg[SQ_STEPS].r[31:0]},
                sq1_c_reg[SQ_STEPS].m[i][15]);
            dv1_reg[i+4][0] <= dv_init(
                {4'd0, 16'(mag33(33'(signed'(sq1_c_reg[SQ_STEPS].p[i])))), 44'd0},
                sq1_c_reg[SQ_STEPS].zero ? 48'd1 : {16'd0, sq1p_reg[SQ_STEPS].r[31:0]},
                sq1_c_reg[SQ_STEPS].p[i][15]);
        end
        for (int l = 0; l < 8; l++)
        begin
            for (int k = 0; k < DIV_STEPS; k++)
                dv1_reg[l][k+1] <= dv_step(dv1_reg[l][k]);
        end
        dv1_zero_reg <= {dv1_zero_reg[DIV_STEPS-1:0], sq1_c_reg[SQ_STEPS].zero};
    end

    // error quaternion conj(p) * m, sign flip, error norm root
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 4; i++)
        begin
            for (int j = 0; j < 4; j++)
                p1_prod_reg[i][j] <= pn32[i] * mn32[j];
        end
        p1_zero_reg <= dv1_zero_reg[DIV_STEPS];

        p2_sum_reg[0] <= p1_prod_reg[0][0] + p1_prod_reg[1][1]
                       + p1_prod_reg[2][2] + p1_prod_reg[3][3];
        p2_sum_reg[1] <= p1_prod_reg[0][1] - p1_prod_reg[1][0]
                       - (p1_prod_reg[2][3] - p1_prod_reg[3][2]);
        p2_sum_reg[2] <= p1_prod_reg[0][2] - p1_prod_reg[2][0]
                       - (p1_prod_reg[3][1] - p1_prod_reg[1][3]);
        p2_sum_reg[3] <= p1_prod_reg[0][3] - p1_prod_reg[3][0]
                       - (p1_prod_reg[1][2] - p1_prod_reg[2][1]);
        p2_zero_reg <= p1_zero_reg;

        for (int i = 0; i < 4; i++)
            p3_e_reg[i] <= rnd30(p2_sum_reg[i]);
        p3_zero_reg <= p2_zero_reg;

        // shortest rotation: flip when the scalar part is negative
        for (int i = 0; i < 4; i++)
            p4_e_reg[i] <= p3_e_reg[0][32] ? -p3_e_reg[i] : p3_e_reg[i];
        p4_zero_reg <= p3_zero_reg;

        for (int i = 0; i < 4; i++)
            p5_sq_reg[i] <= $signed(p4_e_reg[i]) * $signed(p4_e_reg[i]);
        p5_e_reg    <= p4_e_reg;
        p5_zero_reg <= p4_zero_reg;

        p6_s2_reg   <= p5_sq_reg[0] + p5_sq_reg[1] + p5_sq_reg[2] + p5_sq_reg[3];
        p6_e_reg    <= p5_e_reg;
        p6_zero_reg <= p5_zero_reg;

        sq2_reg[0]        <= sq_init(p6_s2_reg);
        sq2_c_reg[0].q    <= p6_e_reg;
        sq2_c_reg[0].zero <= p6_zero_reg;
        for (int k = 0; k < SQ_STEPS; k++)
        begin
            sq2_reg[k+1]   <= sq_step(sq2_reg[k], k);
            sq2_c_reg[k+1] <= sq2_c_reg[k];
        end
    end

    // error normalization and vector norm root
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 4; i++)
        begin
            dv2_reg[i][0] <= dv_init(
                {1'b0, mag33($signed(sq2_c_reg[SQ_STEPS].q[i])), 30'd0},
                zero2 ? 48'd1 : {16'd0, en},
                sq2_c_reg[SQ_STEPS].q[i][32]);
            for (int k = 0; k < DIV_STEPS; k++)
                dv2_reg[i][k+1] <= dv_step(dv2_reg[i][k]);
        end
        dv2_zero_reg <= {dv2_zero_reg[DIV_STEPS-1:0], zero2};

        for (int i = 0; i < 4; i++)
            n1_n_reg[i] <= dv_result(dv2_reg[i][DIV_STEPS]);
        n1_zero_reg <= dv2_zero_reg[DIV_STEPS];
        for (int i = 0; i < 3; i++)
            n1_sq_reg[i] <= dv_result(dv2_reg[i+1][DIV_STEPS])
                          * dv_result(dv2_reg[i+1][DIV_STEPS]);

        n2_s2_reg   <= n1_sq_reg[0] + n1_sq_reg[1] + n1_sq_reg[2];
        n2_n_reg    <= n1_n_reg;
        n2_zero_reg <= n1_zero_reg;

        sq3_reg[0]        <= sq_init(n2_s2_reg);
        sq3_c_reg[0].q    <= n2_n_reg;
        sq3_c_reg[0].zero <= n2_zero_reg;
        for (int k = 0; k < SQ_STEPS; k++)
        begin
            sq3_reg[k+1]   <= sq_step(sq3_reg[k], k);
            sq3_c_reg[k+1] <= sq3_c_reg[k];
        end
    end

    // atan2(|v|, w) by CORDIC, then angle scaling and final division
    always_ff @(posedge clk)
    begin
        cr_reg[0].x <= 36'(signed'(sq3_c_reg[SQ_STEPS].q[0]));
        cr_reg[0].y <= {4'd0, vn};
        cr_reg[0].z <= '0;
        for (int i = 0; i < 3; i++)
            cr_c_reg[0].nv[i] <= sq3_c_reg[SQ_STEPS].q[i+1];
        cr_c_reg[0].vn        <= vn;
        cr_c_reg[0].small_ang <= {1'b0, vn} <= {9'd0, limit_reg, 16'd0};
        cr_c_reg[0].zero      <= sq3_c_reg[SQ_STEPS].zero;
        for (int k = 0; k < CORDIC_STEPS; k++)
        begin
            cr_reg[k+1]   <= cr_step(cr_reg[k], k);
            cr_c_reg[k+1] <= cr_c_reg[k];
        end

        // v * angle, and the small-angle form 2v rounded to Q3.14
        for (int i = 0; i < 3; i++)
        begin
            m1_prod_reg[i] <= $signed(cr_c_reg[CORDIC_STEPS].nv[i]) * angle;
            m1_c_reg.sr[i] <= cr_c_reg[CORDIC_STEPS].nv[i][32]
                ? -20'((mag33($signed(cr_c_reg[CORDIC_STEPS].nv[i])) + 33'd16384) >> 15)
                :  20'((mag33($signed(cr_c_reg[CORDIC_STEPS].nv[i])) + 33'd16384) >> 15);
        end
        m1_c_reg.small_ang <= cr_c_reg[CORDIC_STEPS].small_ang;
        m1_c_reg.zero      <= cr_c_reg[CORDIC_STEPS].zero;
        m1_vn_reg          <= cr_c_reg[CORDIC_STEPS].vn;

        for (int i = 0; i < 3; i++)
        begin
            dv3_reg[i][0] <= dv_init(
                m1_prod_reg[i][67] ? 64'(-m1_prod_reg[i]) : 64'(m1_prod_reg[i]),
                (m1_c_reg.small_ang || m1_vn_reg == 32'd0) ? 48'd1 : {m1_vn_reg, 16'd0},
                m1_prod_reg[i][67]);
            for (int k = 0; k < DIV_STEPS; k++)
                dv3_reg[i][k+1] <= dv_step(dv3_reg[i][k]);
        end
        dv3_c_reg[0] <= m1_c_reg;
        for (int k = 0; k < DIV_STEPS; k++)
            dv3_c_reg[k+1] <= dv3_c_reg[k];

        // select, saturate, clear on degenerate input
        for (int i = 0; i < 3; i++)
        begin
            if (dv3_c_reg[DIV_STEPS].zero)
                rot_reg[i] <= '0;
            else if (dv3_c_reg[DIV_STEPS].small_ang)
                rot_reg[i] <= sat17(33'($signed(dv3_c_reg[DIV_STEPS].sr[i])));
            else
                rot_reg[i] <= sat17(dv_result(dv3_reg[i][DIV_STEPS]));
        end
        degenerate_reg <= dv3_c_reg[DIV_STEPS].zero;
    end

    assign done       = done_reg;
    assign rot_x      = rot_reg[0];
    assign rot_y      = rot_reg[1];
    assign rot_z      = rot_reg[2];
    assign degenerate = degenerate_reg;

    // checks
    `QLAE_ASSERT_NEXT(a_accept_enters, start && !busy, s1_vld_reg, "accepted item lost at entry")
    `QLAE_ASSERT_NEXT(a_result_follows, dv3_vld_reg[DIV_STEPS], done, "result strobe missing")
    `QLAE_ASSERT_NOW(a_degenerate_zero, done && degenerate, rot_x == 17'sd0 && rot_y == 17'sd0 && rot_z == 17'sd0, "degenerate result not zero")
    `QLAE_ASSERT_NOW(a_large_has_norm, cr_vld_reg[0] && !cr_c_reg[0].small_ang, cr_c_reg[0].vn != 32'd0, "CORDIC path with zero norm")

endmodule

`default_nettype wire

// ===== test/quaternion_log_attitude_error_tb.sv =====
// Testbench for quaternion_log_attitude_error: directed and random quaternion pairs,
// several small-angle limits, expected rotation vectors checked in order of arrival.
// Depends on qlae_pkg and the quaternion_log_attitude_error RTL.
`timescale 1ns / 1ps

module quaternion_log_attitude_error_tb;
    import qlae_pkg::*;

    localparam int PIPE_LATENCY = 225;
    localparam int SETTLE_CYCLES = PIPE_LATENCY + 10;
    localparam int ROT_STEPS = 16;
    localparam longint ATAN_Q30 [ROT_STEPS] = '{
        843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
        16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143, 131071,
        65535, 32767
    };

    typedef enum logic [1:0] {ENT_PAIR, ENT_LIMIT, ENT_DRAIN} entry_kind_e;

    typedef struct {
        entry_kind_e kind;
        comp_t       comp [8];
        logic [7:0]  limit;
        int          gap;
    } entry_t;

    typedef struct packed {
        logic signed [16:0] x;
        logic signed [16:0] y;
        logic signed [16:0] z;
        logic               degen;
    } rotvec_t;

    typedef longint quad_t [4];

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic cfg_we;
    logic [7:0] cfg_wdata;
    comp_t mw, mx, my, mz, pw, px, py, pz;
    logic done;
    logic signed [16:0] rot_x, rot_y, rot_z;
    logic degenerate;

    entry_t  pending_q [$];
    rotvec_t rotvec_q [$];
    comp_t   cur_pair [8];
    logic [7:0] limit_copy;
    int gap_left;
    int idle_cycles;
    int mismatches;

    quaternion_log_attitude_error i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .measured_w (mw),
        .measured_x (mx),
        .measured_y (my),
        .measured_z (mz),
        .predicted_w(pw),
        .predicted_x(px),
        .predicted_y(py),
        .predicted_z(pz),
        .done       (done),
        .rot_x      (rot_x),
        .rot_y      (rot_y),
        .rot_z      (rot_z),
        .degenerate (degenerate)
    );

    // clock
    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    // bitwise integer square root
    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end
            else
                res >>= 1;
            bitv >>= 2;
        end
        return res;
    endfunction

    // divide, rounding half away from zero
    function automatic longint div_round(longint n, longint unsigned d);
        longint unsigned mag;
        longint unsigned q;
        mag = (n < 0) ? longint'(-n) : longint'(n);
        q = (mag + d / 2) / d;
        return (n < 0) ? -longint'(q) : longint'(q);
    endfunction

    // scale a Q1.14 quaternion to unit length in Q.30; 0 for zero norm
    function automatic bit unit_q30(quad_t a, output quad_t o);
        longint unsigned s2;
        longint unsigned root;
        s2 = 0;
        for (int i = 0; i < 4; i++)
            s2 += longint'(a[i] * a[i]);
        if (s2 == 0)
            return 1'b0;
        root = int_sqrt(s2 << 28);
        for (int i = 0; i < 4; i++)
            o[i] = div_round(a[i] * (longint'(1) << 44), root);
        return 1'b1;
    endfunction

    // rotation vector of conj(predicted) * measured
    function automatic rotvec_t predict_rotvec(comp_t c [8], logic [7:0] lim);
        quad_t m, p, mn, pn, e, n;
        longint unsigned s2, en, vn;
        longint x, y, z, xs, ys, ang;
        longint r [3];
        rotvec_t o;
        o = '{x: '0, y: '0, z: '0, degen: 1'b1};
        for (int i = 0; i < 4; i++)
        begin
            m[i] = c[i];
            p[i] = c[4 + i];
        end
        if (!unit_q30(m, mn) || !unit_q30(p, pn))
            return o;
        e[0] = div_round(pn[0]*mn[0] + pn[1]*mn[1] + pn[2]*mn[2] + pn[3]*mn[3], 64'd1 << 30);
        e[1] = div_round(pn[0]*mn[1] - mn[0]*pn[1] - (pn[2]*mn[3] - pn[3]*mn[2]), 64'd1 << 30);
        e[2] = div_round(pn[0]*mn[2] - mn[0]*pn[2] - (pn[3]*mn[1] - pn[1]*mn[3]), 64'd1 << 30);
        e[3] = div_round(pn[0]*mn[3] - mn[0]*pn[3] - (pn[1]*mn[2] - pn[2]*mn[1]), 64'd1 << 30);
        // shortest rotation
        if (e[0] < 0)
            for (int i = 0; i < 4; i++)
                e[i] = -e[i];
        s2 = 0;
        for (int i = 0; i < 4; i++)
            s2 += longint'(e[i] * e[i]);
        en = int_sqrt(s2);
        if (en == 0)
            return o;
        for (int i = 0; i < 4; i++)
            n[i] = div_round(e[i] * (longint'(1) << 30), en);
        vn = int_sqrt(longint'(n[1]*n[1]) + longint'(n[2]*n[2]) + longint'(n[3]*n[3]));
        if (vn <= (longint'(lim) << 16))
        begin
            for (int i = 0; i < 3; i++)
                r[i] = div_round(n[1 + i], 64'd1 << 15);
        end
        else
        begin
            // vectoring CORDIC for atan2(vn, w)
            x = n[0];
            y = vn;
            z = 0;
            for (int k = 0; k < ROT_STEPS; k++)
            begin
                xs = x >>> k;
                ys = y >>> k;
                if (y >= 0)
                begin
                    x += ys;
                    y -= xs;
                    z += ATAN_Q30[k];
                end
                else
                begin
                    x -= ys;
                    y += xs;
                    z -= ATAN_Q30[k];
                end
            end
            ang = 2 * z;
            for (int i = 0; i < 3; i++)
                r[i] = div_round(n[1 + i] * ang, vn << 16);
        end
        for (int i = 0; i < 3; i++)
        begin
            if (r[i] < -65536)
                r[i] = -65536;
            else if (r[i] > 65535)
                r[i] = 65535;
        end
        o.x = r[0][16:0];
        o.y = r[1][16:0];
        o.z = r[2][16:0];
        o.degen = 1'b0;
        return o;
    endfunction

    // driver: pairs, limit writes and drain pauses from the pending queue
    always @(posedge clk or negedge rst_n)
    begin
        logic nxt_start;
        logic nxt_we;
        entry_t ent;
        if (!rst_n)
        begin
            start <= 1'b0;
            cfg_we <= 1'b0;
            cfg_wdata <= '0;
            {mw, mx, my, mz, pw, px, py, pz} <= '0;
            limit_copy = LIMIT_RESET;
            gap_left = 0;
            idle_cycles = 0;
        end
        else
        begin
            nxt_start = start;
            nxt_we = 1'b0;
            if (start && !busy)
            begin
                rotvec_q.push_back(predict_rotvec(cur_pair, limit_copy));
                nxt_start = 1'b0;
            end
            idle_cycles = (rotvec_q.size() == 0) ? idle_cycles + 1 : 0;
            if (!nxt_start)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (pending_q.size() != 0)
                begin
                    ent = pending_q[0];
                    case (ent.kind)
                        ENT_PAIR:
                        begin
                            cur_pair = ent.comp;
                            {mw, mx, my, mz} <= {ent.comp[0], ent.comp[1], ent.comp[2],
                                                 ent.comp[3]};
                            {pw, px, py, pz} <= {ent.comp[4], ent.comp[5], ent.comp[6],
                                                 ent.comp[7]};
                            nxt_start = 1'b1;
                            gap_left = ent.gap;
                            void'(pending_q.pop_front());
                        end
                        ENT_LIMIT:
                        begin
                            if (idle_cycles >= SETTLE_CYCLES)
                            begin
                                nxt_we = 1'b1;
                                cfg_wdata <= ent.limit;
                                limit_copy = ent.limit;
                                void'(pending_q.pop_front());
                            end
                        end
                        default:
                        begin
                            if (idle_cycles >= SETTLE_CYCLES)
                                void'(pending_q.pop_front());
                        end
                    endcase
                end
            end
            start <= nxt_start;
            cfg_we <= nxt_we;
        end
    end

    // monitor: compare each strobed result with the oldest prediction
    always @(posedge clk)
    begin
        rotvec_t want;
        if (rst_n && done)
        begin
            if (rotvec_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: rot %0d %0d %0d degenerate %0d",
                             rot_x, rot_y, rot_z, degenerate);
            end
            else
            begin
                want = rotvec_q.pop_front();
                if (rot_x !== want.x || rot_y !== want.y || rot_z !== want.z
                    || degenerate !== want.degen)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: want %0d %0d %0d deg %0d, got %0d %0d %0d deg %0d",
                                 want.x, want.y, want.z, want.degen,
                                 rot_x, rot_y, rot_z, degenerate);
                end
            end
        end
    end

    task automatic add_pair(int a0, int a1, int a2, int a3, int b0, int b1, int b2, int b3,
                            int gap);
        entry_t ent;
        ent.kind = ENT_PAIR;
        ent.comp = '{comp_t'(a0), comp_t'(a1), comp_t'(a2), comp_t'(a3),
                     comp_t'(b0), comp_t'(b1), comp_t'(b2), comp_t'(b3)};
        ent.limit = '0;
        ent.gap = gap;
        pending_q.push_back(ent);
    endtask

    task automatic add_limit(logic [7:0] lim);
        entry_t ent;
        ent.kind = ENT_DRAIN;
        ent.comp = '{default: '0};
        ent.limit = lim;
        ent.gap = 0;
        pending_q.push_back(ent);
        ent.kind = ENT_LIMIT;
        pending_q.push_back(ent);
    endtask

    // random pairs; mostly full range, some close, opposite or extreme pairs for edges
    task automatic add_random(int count);
        int c [8];
        int mode;
        int gap;
        bit burst;
        burst = 1'b0;
        for (int j = 0; j < count; j++)
        begin
            if (j % 40 == 0)
                burst = ($urandom_range(0, 3) == 0);
            gap = burst ? 0 : $urandom_range(0, 11);
            mode = $urandom_range(0, 9);
            for (int i = 0; i < 8; i++)
                c[i] = $signed(16'($urandom));
            if (mode >= 6 && mode <= 8)
                for (int i = 0; i < 4; i++)
                    c[4 + i] = ((mode == 8) ? -c[i] : c[i]) + $urandom_range(0, 64) - 32;
            else if (mode == 9)
                for (int i = 0; i < 8; i++)
                    case ($urandom_range(0, 3))
                        0: c[i] = 0;
                        1: c[i] = -32768;
                        2: c[i] = 32767;
                        default: c[i] = $urandom_range(0, 3) - 1;
                    endcase
            add_pair(c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7], gap);
        end
    endtask

    // stimulus and end of run
    initial
    begin
        rst_n = 1'b0;
        mismatches = 0;
        // directed: zero norms, extremes, identity, flip, zero scalar, half turn
        add_pair(0, 0, 0, 0, 16384, 0, 0, 0, 0);
        add_pair(16384, 0, 0, 0, 0, 0, 0, 0, 3);
        add_pair(0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_pair(-32768, -32768, -32768, -32768, 32767, 32767, 32767, 32767, 1);
        add_pair(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 0);
        add_pair(16384, 0, 0, 0, 16384, 0, 0, 0, 0);
        add_pair(16384, 100, -200, 300, -16384, -100, 200, -300, 2);
        add_pair(0, 16384, 0, 0, 16384, 0, 0, 0, 0);
        add_pair(0, 0, 0, 16384, 16384, 0, 0, 0, 5);
        add_pair(-16384, 0, 16384, 0, 16384, 0, 0, 0, 0);
        add_pair(1, 0, 0, 0, 0, -1, 0, 0, 0);
        add_pair(16384, 1, 0, 0, 16384, 0, 0, 0, 11);
        add_pair(16384, 0, 2, 0, 16384, 0, 0, 0, 0);
        add_pair(16384, 0, 0, 40, 16384, 0, 0, 0, 0);
        add_pair(11585, 11585, 0, 0, 16384, 0, 0, 0, 0);
        add_pair(-32768, 32767, -1, 1, 1, -1, 32767, -32768, 4);
        add_pair(16384, 0, 0, 0, 16383, 0, 0, 0, 0);
        add_limit(8'd0);
        add_pair(16384, 0, 0, 0, 16384, 0, 0, 0, 0);
        add_pair(16384, 1, 0, 0, 16384, 0, 0, 0, 0);
        add_limit(8'd255);
        add_pair(16384, 200, 0, 0, 16384, 0, 0, 0, 0);
        add_pair(16384, 255, 0, 0, 16384, 0, 0, 0, 0);
        add_pair(16384, 300, 0, 0, 16384, 0, 0, 0, 0);
        // random phases over several limits
        add_random(300);
        add_limit(8'd0);
        add_random(300);
        add_limit(8'd1);
        add_random(300);
        add_limit(8'($urandom_range(2, 254)));
        add_random(200);
        add_limit(8'd255);
        add_random(150);
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        wait (pending_q.size() == 0);
        @(posedge clk);
        wait (rotvec_q.size() == 0);
        repeat (PIPE_LATENCY + 20) @(posedge clk);
        if (mismatches == 0 && rotvec_q.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // watchdog
    initial
    begin
        #5ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/qlae_pkg.sv
rtl/quaternion_log_attitude_error.sv
test/quaternion_log_attitude_error_tb.sv
